FILE: hw/rtl/cau_pkg.sv
// Shared types and constants for the column aggregate unit.
// Holds the row and result word formats, function and column-kind codes,
// and the command/status bundles between controller and datapath.
`default_nettype none

package cau_pkg;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned FnW      = 3;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 3;

  localparam logic [ValueW-1:0] SignBit = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic [ValueW-1:0] MaxVal  = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic [ValueW-1:0] MinVal  = SignBit;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FUNCTION = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KIND     = 2'd1;

  typedef enum logic [FnW-1:0] {
    FN_COUNT = 3'd0,
    FN_SUM   = 3'd1,
    FN_AVG   = 3'd2,
    FN_MIN   = 3'd3,
    FN_MAX   = 3'd4
  } fn_e;

  typedef enum logic [KindW-1:0] {
    KIND_INT  = 2'd0,
    KIND_REAL = 2'd1,
    KIND_DATE = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [ValueW-1:0] row_value;
    logic                     last_row;
  } in_word_t;

  typedef struct packed {
    logic signed [ValueW-1:0] aggregate_value;
    logic [KindW-1:0]         value_format;
    logic                     overflow;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic row_upd;
    logic out_load;
    logic div_load;
    logic div_prep;
    logic div_step;
    logic div_finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_needed;
    logic div_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cau_ctrl.sv
// Controller of the column aggregate unit: row acceptance, divide sequencing
// and the valid flag of the result register. Uses cau_pkg.
`default_nettype none

module cau_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_last_i,
  output logic                 in_ready_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  input  wire cau_pkg::status_t status_i,
  output cau_pkg::cmd_t        cmd_o
);
  import cau_pkg::*;

  typedef enum logic [2:0] {
    ST_ROWS = 3'b001,
    ST_PREP = 3'b010,
    ST_DIV  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  // A last row needs the result register free by the time it loads
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_ROWS) && (!in_last_i || out_free);
  assign accept     = in_valid_i && in_ready_o;

  // Sequence rows, then the divide for an average
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_ROWS: begin
        cmd_o.row_upd = accept;
        if (accept && in_last_i) begin
          if (status_i.div_needed) begin
            cmd_o.div_load = 1'b1;
            state_d        = ST_PREP;
          end else begin
            cmd_o.out_load = 1'b1;
          end
        end
      end
      ST_PREP: begin
        cmd_o.div_prep = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_busy) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.div_finish = 1'b1;
          state_d          = ST_ROWS;
        end
      end
      default: begin
        state_d = ST_ROWS;
      end
    endcase
  end

  // Drop valid when taken, raise it on a new result
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.out_load || cmd_o.div_finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ROWS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cau_datapath.sv
// Datapath of the column aggregate unit: configuration registers, per-row
// count/sum/extreme update, restoring divider for the average and the
// result register. Uses cau_pkg.
`default_nettype none

module cau_datapath #(
  parameter int unsigned COUNT_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [cau_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [cau_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire cau_pkg::in_word_t              row_i,
  input  wire cau_pkg::cmd_t                  cmd_i,
  output cau_pkg::status_t                    status_o,
  output cau_pkg::out_word_t                  out_data_o
);
  import cau_pkg::*;

  localparam int unsigned DivW  = ValueW + FRACTION_BITS;
  localparam int unsigned StepW = $clog2(DivW + 1);
  localparam logic [StepW-1:0] IntSteps  = StepW'(DivW);
  localparam logic [StepW-1:0] RealSteps = StepW'(ValueW);

  // Configuration
  logic [FnW-1:0]   fn_q;
  logic [KindW-1:0] kind_q;
  fn_e              fn_eff;
  kind_e            kind_eff;

  // Table state
  logic [ValueW-1:0]     tot_q, tot_nx;
  logic [COUNT_BITS-1:0] cnt_q, cnt_nx;
  logic [ValueW-1:0]     ext_q, ext_nx;
  logic                  seen_q, seen_nx;
  logic                  ovf_q, ovf_nx;

  logic [ValueW-1:0] v;
  logic [ValueW-1:0] sum_raw;
  logic              add_en, add_sat, cnt_full;
  logic              minmax, take, less, greater;

  out_word_t direct_res, div_res;
  out_word_t out_q;

  // Divider
  logic [DivW-1:0]       num_q;
  logic [COUNT_BITS-1:0] den_q, rem_q;
  logic [ValueW-1:0]     quo_q;
  logic                  big_q, neg_q, dovf_q;
  logic [StepW-1:0]      steps_q;
  logic [COUNT_BITS:0]   rem_sh, rem_diff;
  logic                  rem_ge;
  logic [ValueW-1:0]     num_top, num_mag;
  logic                  q_sat;

  // Write configuration; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_q   <= FN_COUNT;
      kind_q <= KIND_INT;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FUNCTION) begin
        fn_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_KIND) begin
        kind_q <= cfg_data_i[KindW-1:0];
      end
    end
  end

  // Map unused codes: function acts as count, kind as integer
  always_comb begin
    case (fn_q)
      FN_SUM:  fn_eff = FN_SUM;
      FN_AVG:  fn_eff = FN_AVG;
      FN_MIN:  fn_eff = FN_MIN;
      FN_MAX:  fn_eff = FN_MAX;
      default: fn_eff = FN_COUNT;
    endcase
    case (kind_q)
      KIND_REAL: kind_eff = KIND_REAL;
      KIND_DATE: kind_eff = KIND_DATE;
      default:   kind_eff = KIND_INT;
    endcase
  end

  assign v = row_i.row_value;

  // Saturating row count
  assign cnt_full = &cnt_q;
  assign cnt_nx   = cnt_full ? cnt_q : cnt_q + 1'b1;

  // Saturating running total
  assign add_en  = ((fn_eff == FN_SUM) || (fn_eff == FN_AVG)) && (kind_eff != KIND_DATE);
  assign sum_raw = tot_q + v;
  assign add_sat = add_en && (tot_q[ValueW-1] == v[ValueW-1])
                   && (sum_raw[ValueW-1] != tot_q[ValueW-1]);
  always_comb begin
    if (!add_en) begin
      tot_nx = tot_q;
    end else if (add_sat) begin
      tot_nx = tot_q[ValueW-1] ? MinVal : MaxVal;
    end else begin
      tot_nx = sum_raw;
    end
  end
  assign ovf_nx = ovf_q || cnt_full || add_sat;

  // Track minimum or maximum; datetime keys compare unsigned
  assign minmax  = (fn_eff == FN_MIN) || (fn_eff == FN_MAX);
  assign less    = (kind_eff == KIND_DATE) ? (v < ext_q) : ($signed(v) < $signed(ext_q));
  assign greater = (kind_eff == KIND_DATE) ? (v > ext_q) : ($signed(v) > $signed(ext_q));
  assign take    = !seen_q || ((fn_eff == FN_MIN) ? less : greater);
  assign ext_nx  = (minmax && take) ? v : ext_q;
  assign seen_nx = seen_q || minmax;

  // Update table state; clear it after the last row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= '0;
      cnt_q  <= '0;
      ext_q  <= '0;
      seen_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.row_upd) begin
      if (row_i.last_row) begin
        tot_q  <= '0;
        cnt_q  <= '0;
        ext_q  <= '0;
        seen_q <= 1'b0;
        ovf_q  <= 1'b0;
      end else begin
        tot_q  <= tot_nx;
        cnt_q  <= cnt_nx;
        ext_q  <= ext_nx;
        seen_q <= seen_nx;
        ovf_q  <= ovf_nx;
      end
    end
  end

  // Result that needs no divide
  always_comb begin
    direct_res = '0;
    case (fn_eff)
      FN_SUM: begin
        if (kind_eff != KIND_DATE) begin
          direct_res.aggregate_value = tot_nx;
          direct_res.value_format    = kind_eff;
          direct_res.overflow        = ovf_nx;
        end
      end
      FN_AVG: begin
        direct_res.value_format = KIND_REAL;
      end
      FN_MIN, FN_MAX: begin
        direct_res.aggregate_value = ext_nx;
        direct_res.value_format    = kind_eff;
      end
      default: begin
        direct_res.aggregate_value = ValueW'(cnt_nx);
        direct_res.value_format    = KIND_INT;
        direct_res.overflow        = ovf_nx;
      end
    endcase
  end

  assign status_o.div_needed = (fn_eff == FN_AVG) && (kind_eff != KIND_DATE);
  assign status_o.div_busy   = (steps_q != '0);

  // Restoring divide step: one quotient bit a cycle
  assign rem_sh   = {rem_q, num_q[DivW-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_q};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign num_top  = num_q[DivW-1 -: ValueW];
  assign num_mag  = neg_q ? (ValueW'(0) - num_top) : num_top;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      num_q   <= {tot_nx, {FRACTION_BITS{1'b0}}};
      neg_q   <= tot_nx[ValueW-1];
      den_q   <= cnt_nx;
      dovf_q  <= ovf_nx;
      rem_q   <= '0;
      quo_q   <= '0;
      big_q   <= 1'b0;
      steps_q <= (kind_eff == KIND_INT) ? IntSteps : RealSteps;
    end else if (cmd_i.div_prep) begin
      // Divide the magnitude, apply the sign at the end
      num_q[DivW-1 -: ValueW] <= num_mag;
    end else if (cmd_i.div_step) begin
      num_q   <= {num_q[DivW-2:0], 1'b0};
      rem_q   <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
      quo_q   <= {quo_q[ValueW-2:0], rem_ge};
      big_q   <= big_q || quo_q[ValueW-1];
      steps_q <= steps_q - 1'b1;
    end
  end

  // Sign and saturate the quotient
  assign q_sat = neg_q ? (big_q || (quo_q > SignBit)) : (big_q || quo_q[ValueW-1]);
  always_comb begin
    div_res              = '0;
    div_res.value_format = KIND_REAL;
    div_res.overflow     = dovf_q || q_sat;
    if (neg_q) begin
      div_res.aggregate_value = q_sat ? MinVal : (ValueW'(0) - quo_q);
    end else begin
      div_res.aggregate_value = q_sat ? MaxVal : quo_q;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= direct_res;
    end else if (cmd_i.div_finish) begin
      out_q <= div_res;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/column_aggregate_unit.sv
// Top level of the column aggregate unit: controller and datapath.
// Depends on cau_pkg, cau_ctrl and cau_datapath.
//
// Rows enter one word per cycle; each updates the row count, the saturating
// total and the running minimum or maximum. The row marked last closes the
// table and yields one result word. COUNT, SUM, MIN and MAX results, and AVG
// over a datetime column, sit in the output register in the cycle after the
// last row is taken. AVG over a numeric column loads a restoring divider,
// takes the magnitude, makes one quotient bit a cycle, then signs and
// saturates the quotient; no row is taken until it is done. A last row waits
// until the output register is free; other rows flow while an earlier result
// waits. Configuration writes are always ready.
`default_nettype none

module column_aggregate_unit #(
  parameter int unsigned COUNT_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire cau_pkg::in_word_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output cau_pkg::out_word_t                out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [cau_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cau_pkg::CfgDataW-1:0] cfg_data_i
);
  import cau_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  cau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_row),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cau_datapath #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .row_i       (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: verif/column_aggregate_unit_tb.sv
// Self-checking testbench for column_aggregate_unit: streams tables of rows,
// predicts each COUNT/SUM/AVG/MIN/MAX word and checks every result word.
// Depends on cau_pkg and the column_aggregate_unit RTL only.
module column_aggregate_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cau_pkg::*;

  localparam int unsigned CountBits  = 32;
  localparam int unsigned FracBits   = 32;
  localparam logic [FnW-1:0]   FnSpareTop = 3'd7;  // highest unused function code
  localparam logic [KindW-1:0] KindSpare  = 2'd3;  // unused column kind
  localparam int unsigned RandomRows = 1100;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 120;        // covers the full AVG divide

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  column_aggregate_unit #(
    .COUNT_BITS(CountBits),
    .FRACTION_BITS(FracBits)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow registers and per-table accumulators of the predictor
  logic [FnW-1:0]       fn_cfg = '0;
  logic [KindW-1:0]     kind_cfg = '0;
  logic [ValueW-1:0]    total_acc = '0;
  logic [CountBits-1:0] rows_seen = '0;
  logic [ValueW-1:0]    extreme_acc = '0;
  logic                 extreme_held = 1'b0;
  logic                 sat_seen = 1'b0;

  in_word_t  rows_pending[$];
  out_word_t aggregates_due[$];
  int unsigned rows_queued = 0;
  int unsigned rows_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned gap_rate = 0;
  int unsigned stall_rate = 0;
  bit calm = 1'b0;
  out_word_t want;

  // Fold one accepted row into the table state; on a last row queue the aggregate
  function automatic void fold_row(input in_word_t w);
    fn_e f;
    kind_e k;
    logic [ValueW-1:0] v;
    logic [ValueW-1:0] s;
    logic [ValueW-1:0] mag;
    logic [127:0] quo;
    logic take;
    out_word_t r;
    int unsigned sh;
    v = w.row_value;
    f = (fn_cfg > FN_MAX) ? FN_COUNT : fn_e'(fn_cfg);
    k = (kind_cfg > KIND_DATE) ? KIND_INT : kind_e'(kind_cfg);
    rows_taken++;

    // Count saturates at all ones
    if (rows_seen == '1) sat_seen = 1'b1;
    else rows_seen++;

    // Saturating total for sum and avg over numeric columns
    if ((f == FN_SUM || f == FN_AVG) && k != KIND_DATE) begin
      s = total_acc + v;
      if (total_acc[ValueW-1] == v[ValueW-1] && s[ValueW-1] != total_acc[ValueW-1]) begin
        sat_seen = 1'b1;
        s = total_acc[ValueW-1] ? MinVal : MaxVal;
      end
      total_acc = s;
    end

    // Running extreme: unsigned order for datetime keys, signed otherwise
    if (f == FN_MIN || f == FN_MAX) begin
      if (!extreme_held) take = 1'b1;
      else if (k == KIND_DATE) take = (f == FN_MIN) ? (v < extreme_acc) : (v > extreme_acc);
      else take = (f == FN_MIN) ? ($signed(v) < $signed(extreme_acc))
                                : ($signed(v) > $signed(extreme_acc));
      if (take) extreme_acc = v;
      extreme_held = 1'b1;
    end

    if (w.last_row) begin
      r.aggregate_value = '0;
      r.value_format = KIND_INT;
      r.overflow = 1'b0;
      case (f)
        FN_SUM: begin
          if (k != KIND_DATE) begin
            r.aggregate_value = total_acc;
            r.value_format = k;
            r.overflow = sat_seen;
          end
        end
        FN_AVG: begin
          r.value_format = KIND_REAL;
          if (k != KIND_DATE) begin
            // Divide magnitude, truncate toward zero, saturate to 64 bits
            r.overflow = sat_seen;
            sh = (k == KIND_INT) ? FracBits : 0;
            mag = total_acc[ValueW-1] ? -total_acc : total_acc;
            quo = ({64'd0, mag} << sh) / {{(128-CountBits){1'b0}}, rows_seen};
            if (total_acc[ValueW-1]) begin
              if (quo > {64'd0, SignBit}) begin
                r.overflow = 1'b1;
                r.aggregate_value = MinVal;
              end else begin
                r.aggregate_value = -quo[ValueW-1:0];
              end
            end else if (quo > {64'd0, MaxVal}) begin
              r.overflow = 1'b1;
              r.aggregate_value = MaxVal;
            end else begin
              r.aggregate_value = quo[ValueW-1:0];
            end
          end
        end
        FN_MIN, FN_MAX: begin
          r.aggregate_value = extreme_acc;
          r.value_format = k;
        end
        default: begin
          r.aggregate_value = ValueW'(rows_seen);
          r.overflow = sat_seen;
        end
      endcase
      aggregates_due.insert(aggregates_due.size(), r);
      total_acc = '0;
      rows_seen = '0;
      extreme_acc = '0;
      extreme_held = 1'b0;
      sat_seen = 1'b0;
    end
  endfunction

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Row driver: predict on accept, then present the next word or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) fold_row(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (!calm && gap_rate != 0 && $urandom_range(0, 99) < gap_rate) begin
          gap_left <= $urandom_range(0, 17);
          in_valid_i <= 1'b0;
        end else if (rows_pending.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= rows_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted word against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (aggregates_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected aggregate: value %h format %0d overflow %0b",
                     out_data_o.aggregate_value, out_data_o.value_format,
                     out_data_o.overflow);
        end else begin
          want = aggregates_due.pop_front();
          if (out_data_o.aggregate_value !== want.aggregate_value ||
              out_data_o.value_format !== want.value_format ||
              out_data_o.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("aggregate mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                       want.aggregate_value, want.value_format, want.overflow,
                       out_data_o.aggregate_value, out_data_o.value_format,
                       out_data_o.overflow);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && stall_rate != 0 && $urandom_range(0, 99) < stall_rate) begin
        stall_left <= $urandom_range(0, 17);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Write both registers; call at a clock edge
  task automatic write_regs(input logic [FnW-1:0] f, input logic [KindW-1:0] k);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FUNCTION;
    cfg_data_i <= f;
    do @(posedge clk_i); while (!cfg_ready_o);
    fn_cfg = f;
    cfg_index_i <= CFG_KIND;
    cfg_data_i <= CfgDataW'(k);
    do @(posedge clk_i); while (!cfg_ready_o);
    kind_cfg = k;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_row(input logic [ValueW-1:0] v, input logic l);
    in_word_t w;
    w.row_value = v;
    w.last_row = l;
    rows_pending.insert(rows_pending.size(), w);
    rows_queued++;
  endtask

  // Wait until every row is taken and every aggregate seen, then let the block settle
  task automatic settle();
    do @(posedge clk_i); while (rows_taken != rows_queued || aggregates_due.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned target;
    int unsigned tables;
    int unsigned len;
    int unsigned mode;
    logic [FnW-1:0] f;
    logic [KindW-1:0] k;
    logic [ValueW-1:0] v;
    bit open_end;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    gap_rate = 20;
    stall_rate = 20;

    // Directed: one-row count
    write_regs(FN_COUNT, KIND_INT);
    push_row(64'd5, 1'b1);
    settle();
    // Sum saturating high, then low
    write_regs(FN_SUM, KIND_INT);
    push_row(MaxVal, 1'b0);
    push_row(64'd1, 1'b1);
    push_row(MinVal, 1'b0);
    push_row(-64'd1, 1'b1);
    settle();
    // Avg truncating toward zero, quotient saturating both ways
    write_regs(FN_AVG, KIND_INT);
    push_row(-64'd7, 1'b0);
    push_row(64'd2, 1'b1);
    push_row(MaxVal, 1'b1);
    push_row(MinVal, 1'b1);
    settle();
    write_regs(FN_AVG, KIND_REAL);
    push_row(-64'd1, 1'b0);
    push_row(64'h0000_0001_0000_0000, 1'b1);
    settle();
    // Datetime min uses unsigned order
    write_regs(FN_MIN, KIND_DATE);
    push_row(SignBit, 1'b0);
    push_row(64'd1, 1'b0);
    push_row('1, 1'b1);
    settle();
    write_regs(FN_MAX, KIND_INT);
    push_row(MinVal, 1'b0);
    push_row(MaxVal, 1'b1);
    settle();
    // Sum and avg over datetimes give zero
    write_regs(FN_SUM, KIND_DATE);
    push_row(64'd7, 1'b0);
    push_row(64'd9, 1'b1);
    settle();
    write_regs(FN_AVG, KIND_DATE);
    push_row(64'd7, 1'b1);
    settle();
    // Unused codes fall back to count and to integer
    write_regs(FnSpareTop, KindSpare);
    push_row(64'd1, 1'b0);
    push_row(64'd2, 1'b1);
    settle();
    write_regs(FN_MIN, KindSpare);
    push_row(64'd5, 1'b0);
    push_row(-64'd5, 1'b1);
    settle();
    // Registers changed in the middle of a table
    write_regs(FN_SUM, KIND_INT);
    push_row(64'd10, 1'b0);
    settle();
    write_regs(FN_MAX, KIND_REAL);
    push_row(64'd3, 1'b1);
    settle();

    // Random phases of whole tables, a few left open across a register change
    target = rows_queued + RandomRows;
    while (rows_queued < target) begin
      calm = (rows_queued + 120 > target);
      case ($urandom_range(0, 3))
        0: gap_rate = 0;
        1: gap_rate = 5;
        2: gap_rate = 20;
        default: gap_rate = 50;
      endcase
      case ($urandom_range(0, 3))
        0: stall_rate = 0;
        1: stall_rate = 5;
        2: stall_rate = 20;
        default: stall_rate = 50;
      endcase
      f = ($urandom_range(0, 9) == 0) ? FnW'($urandom_range(FN_MAX + 1, FnSpareTop))
                                       : FnW'($urandom_range(FN_COUNT, FN_MAX));
      k = ($urandom_range(0, 9) == 0) ? KindSpare : KindW'($urandom_range(KIND_INT, KIND_DATE));
      write_regs(f, k);
      tables = $urandom_range(1, 6);
      open_end = ($urandom_range(0, 7) == 0);
      for (int t = 0; t < tables; t++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        mode = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
          case (mode)
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 2000)) - 64'd1000;
            2: v = $urandom_range(0, 1) ? MaxVal - 64'($urandom_range(0, 3))
                                        : MinVal + 64'($urandom_range(0, 3));
            default: begin
              if (k == KIND_DATE)
                v = {8'h00, 16'($urandom_range(1970, 2100)), 8'($urandom_range(1, 12)),
                     8'($urandom_range(1, 28)), 8'($urandom_range(0, 23)),
                     8'($urandom_range(0, 59)), 8'($urandom_range(0, 59))};
              else
                v = {32'($urandom_range(0, 200)) - 32'd100, $urandom};
            end
          endcase
          push_row(v, (i == len - 1) && !(open_end && t == tables - 1));
        end
      end
      settle();
    end

    // Close any table left open, then drain
    write_regs(FN_COUNT, KIND_INT);
    push_row({$urandom, $urandom}, 1'b1);
    settle();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && aggregates_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/cau_pkg.sv
hw/rtl/cau_ctrl.sv
hw/rtl/cau_datapath.sv
hw/rtl/column_aggregate_unit.sv
verif/column_aggregate_unit_tb.sv
